### src/hsf_pkg.sv
`timescale 1ns / 1ps
// Constants, types and helper functions of the 20-node hexahedron shape function unit.
package hsf_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 17;
    localparam int NODE_W     = 5;
    localparam int NODE_COUNT = 20;

    localparam int FW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 4;
    localparam int PW = 2 * FW;
    localparam int RW = 4 * FW + 1;

    localparam int unsigned KV = 3 * FRAC_BITS + 3;
    localparam int unsigned KD = 2 * FRAC_BITS + 3;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);

    localparam logic signed [FW-1:0] ONE_F =
        {{(FW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [FW-1:0] TWO_F =
        {{(FW - FRAC_BITS - 2){1'b0}}, 1'b1, {(FRAC_BITS + 1){1'b0}}};

    localparam logic signed [1:0] NEG = -2'sd1;
    localparam logic signed [1:0] POS = 2'sd1;
    localparam logic signed [1:0] ZRO = 2'sd0;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_CORNER,
        KIND_MID_XI,
        KIND_MID_ETA,
        KIND_MID_ZETA
    } t_node_kind;

    typedef struct packed {
        logic signed [1:0] a;
        logic signed [1:0] b;
        logic signed [1:0] c;
        t_node_kind        kind;
    } t_node_info;

    function automatic t_node_info node_info(input logic [NODE_W-1:0] n);
        logic [5:0] abc;
        t_node_info info;
        unique case (n)
            5'd0:    abc = {NEG, NEG, NEG};
            5'd1:    abc = {POS, NEG, NEG};
            5'd2:    abc = {POS, POS, NEG};
            5'd3:    abc = {NEG, POS, NEG};
            5'd4:    abc = {NEG, NEG, POS};
            5'd5:    abc = {POS, NEG, POS};
            5'd6:    abc = {POS, POS, POS};
            5'd7:    abc = {NEG, POS, POS};
            5'd8:    abc = {ZRO, NEG, NEG};
            5'd9:    abc = {POS, ZRO, NEG};
            5'd10:   abc = {ZRO, POS, NEG};
            5'd11:   abc = {NEG, ZRO, NEG};
            5'd12:   abc = {NEG, NEG, ZRO};
            5'd13:   abc = {POS, NEG, ZRO};
            5'd14:   abc = {POS, POS, ZRO};
            5'd15:   abc = {NEG, POS, ZRO};
            5'd16:   abc = {ZRO, NEG, POS};
            5'd17:   abc = {POS, ZRO, POS};
            5'd18:   abc = {ZRO, POS, POS};
            5'd19:   abc = {NEG, ZRO, POS};
            default: abc = {NEG, NEG, NEG};
        endcase
        info.a = abc[5:4];
        info.b = abc[3:2];
        info.c = abc[1:0];
        if (info.a == ZRO) begin
            info.kind = KIND_MID_XI;
        end else if (info.b == ZRO) begin
            info.kind = KIND_MID_ETA;
        end else if (info.c == ZRO) begin
            info.kind = KIND_MID_ZETA;
        end else begin
            info.kind = KIND_CORNER;
        end
        return info;
    endfunction

    function automatic logic signed [FW-1:0] neg_if(input logic neg,
                                                    input logic signed [FW-1:0] v);
        return neg ? -v : v;
    endfunction

    // round half up, then saturate
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [RW-1:0] p,
                                                          input int unsigned k);
        logic signed [RW-1:0] half;
        logic signed [RW-1:0] q;
        logic [RW-OUT_W:0]    top;
        half = '0;
        half[k - 1] = 1'b1;
        q = (p + half) >>> k;
        top = q[RW-1:OUT_W-1];
        if ((top == '0) || (top == '1)) begin
            return q[OUT_W-1:0];
        end else if (q[RW-1]) begin
            return OUT_MIN;
        end else begin
            return OUT_MAX;
        end
    endfunction

endpackage

### src/hex20_shape_function_eval.sv
`timescale 1ns / 1ps
// Top level: node sequencer and five-stage shape function datapath.
//
// A point (xi, eta, zeta) is taken into a holding register and a node sequencer
// issues its 20 nodes, one per cycle while the output is not stalled, into a
// five-stage datapath (factor forming, two multiply stages, product assembly,
// rounding and saturation). Results come out one word per cycle when not
// stalled, node 0 first, with o_last_node on node 19. The next point is taken in
// the cycle its predecessor's last node issues, while earlier nodes are still in
// the datapath. A stall on the output holds the whole datapath and the sequencer.
module hex20_shape_function_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [hsf_pkg::IN_W-1:0]     i_xi_coord,
    input  logic signed [hsf_pkg::IN_W-1:0]     i_eta_coord,
    input  logic signed [hsf_pkg::IN_W-1:0]     i_zeta_coord,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [hsf_pkg::NODE_W-1:0]   o_node_number,
    output logic signed [hsf_pkg::OUT_W-1:0]    o_shape_value,
    output logic signed [hsf_pkg::OUT_W-1:0]    o_deriv_xi,
    output logic signed [hsf_pkg::OUT_W-1:0]    o_deriv_eta,
    output logic signed [hsf_pkg::OUT_W-1:0]    o_deriv_zeta,
    output logic                                o_last_node
);

    localparam int FW    = hsf_pkg::FW;
    localparam int PW    = hsf_pkg::PW;
    localparam int IN_W  = hsf_pkg::IN_W;
    localparam int NW    = hsf_pkg::NODE_W;

    logic en;
    logic in_acc;
    logic issue_last;

    // sequencer
    logic                   r_busy, n_busy;
    logic [NW-1:0]          r_node, n_node;
    logic signed [IN_W-1:0] r_x, r_y, r_z;

    // stage 1: factors
    logic                   r1_valid;
    logic [NW-1:0]          r1_node;
    logic                   r1_last;
    logic signed [FW-1:0]   r1_vf [4];
    logic signed [FW-1:0]   r1_df [3][3];
    logic signed [FW-1:0]   n1_vf [4];
    logic signed [FW-1:0]   n1_df [3][3];

    // stage 2: pair products
    logic                   r2_valid;
    logic [NW-1:0]          r2_node;
    logic                   r2_last;
    logic signed [PW-1:0]   r2_pv01, r2_pv23;
    logic signed [PW-1:0]   r2_d01 [3];
    logic signed [FW-1:0]   r2_d2 [3];

    // stage 3: split products
    logic                   r3_valid;
    logic [NW-1:0]          r3_node;
    logic                   r3_last;
    logic signed [PW+FW-1:0] r3_vhi;
    logic signed [PW+FW:0]   r3_vlo;
    logic signed [3*FW-1:0]  r3_d [3];

    // stage 4: full products
    logic                   r4_valid;
    logic [NW-1:0]          r4_node;
    logic                   r4_last;
    logic signed [4*FW-1:0] r4_v;
    logic signed [3*FW-1:0] r4_d [3];

    // stage 5: output word
    logic                   r5_valid;

    hsf_pkg::t_node_info info;
    logic signed [FW-1:0] x_e, y_e, z_e;
    logic signed [FW-1:0] ax, by, cz, px, py, pz, s;
    logic signed [FW-1:0] mx2, my2, mz2, qx, qy, qz;

    assign en         = !(r5_valid && i_stall);
    assign issue_last = (r_node == hsf_pkg::LAST_NODE);
    assign o_stall    = r_busy && !(en && issue_last);
    assign in_acc     = i_valid && !o_stall;
    assign o_valid    = r5_valid;

    always_comb begin
        n_busy = r_busy;
        n_node = r_node;
        if (en && r_busy) begin
            if (issue_last) begin
                n_busy = 1'b0;
            end else begin
                n_node = r_node + NW'(1);
            end
        end
        if (in_acc) begin
            n_busy = 1'b1;
            n_node = '0;
        end
    end

    always_comb begin
        info = hsf_pkg::node_info(r_node);
        x_e  = {{(FW - IN_W){r_x[IN_W-1]}}, r_x};
        y_e  = {{(FW - IN_W){r_y[IN_W-1]}}, r_y};
        z_e  = {{(FW - IN_W){r_z[IN_W-1]}}, r_z};
        ax   = (info.a == hsf_pkg::ZRO) ? '0 : hsf_pkg::neg_if(info.a[1], x_e);
        by   = (info.b == hsf_pkg::ZRO) ? '0 : hsf_pkg::neg_if(info.b[1], y_e);
        cz   = (info.c == hsf_pkg::ZRO) ? '0 : hsf_pkg::neg_if(info.c[1], z_e);
        px   = hsf_pkg::ONE_F + ax;
        py   = hsf_pkg::ONE_F + by;
        pz   = hsf_pkg::ONE_F + cz;
        s    = ax + by + cz;
        mx2  = (hsf_pkg::ONE_F - x_e) <<< 1;
        my2  = (hsf_pkg::ONE_F - y_e) <<< 1;
        mz2  = (hsf_pkg::ONE_F - z_e) <<< 1;
        qx   = hsf_pkg::ONE_F + x_e;
        qy   = hsf_pkg::ONE_F + y_e;
        qz   = hsf_pkg::ONE_F + z_e;

        n1_vf = '{px, py, pz, s - hsf_pkg::TWO_F};
        n1_df = '{'{px, py, pz}, '{px, py, pz}, '{px, py, pz}};
        unique case (info.kind)
            hsf_pkg::KIND_CORNER: begin
                n1_vf = '{px, py, pz, s - hsf_pkg::TWO_F};
                n1_df = '{'{hsf_pkg::neg_if(info.a[1], py), pz, s + ax - hsf_pkg::ONE_F},
                          '{hsf_pkg::neg_if(info.b[1], px), pz, s + by - hsf_pkg::ONE_F},
                          '{hsf_pkg::neg_if(info.c[1], px), py, s + cz - hsf_pkg::ONE_F}};
            end
            hsf_pkg::KIND_MID_XI: begin
                n1_vf = '{mx2, qx, py, pz};
                n1_df = '{'{-(x_e <<< 2), py, pz},
                          '{hsf_pkg::neg_if(info.b[1], mx2), qx, pz},
                          '{hsf_pkg::neg_if(info.c[1], mx2), qx, py}};
            end
            hsf_pkg::KIND_MID_ETA: begin
                n1_vf = '{px, my2, qy, pz};
                n1_df = '{'{hsf_pkg::neg_if(info.a[1], my2), qy, pz},
                          '{-(y_e <<< 2), px, pz},
                          '{hsf_pkg::neg_if(info.c[1], my2), qy, px}};
            end
            hsf_pkg::KIND_MID_ZETA: begin
                n1_vf = '{px, py, mz2, qz};
                n1_df = '{'{hsf_pkg::neg_if(info.a[1], mz2), qz, py},
                          '{hsf_pkg::neg_if(info.b[1], mz2), qz, px},
                          '{-(z_e <<< 2), px, py}};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_node   <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_node <= n_node;
            if (en) begin
                r1_valid <= r_busy;
                r2_valid <= r1_valid;
                r3_valid <= r2_valid;
                r4_valid <= r3_valid;
                r5_valid <= r4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_xi_coord;
            r_y <= i_eta_coord;
            r_z <= i_zeta_coord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_node <= r_node;
            r1_last <= issue_last;
            r1_vf   <= n1_vf;
            r1_df   <= n1_df;

            r2_node <= r1_node;
            r2_last <= r1_last;
            r2_pv01 <= r1_vf[0] * r1_vf[1];
            r2_pv23 <= r1_vf[2] * r1_vf[3];
            for (int i = 0; i < 3; i++) begin
                r2_d01[i] <= r1_df[i][0] * r1_df[i][1];
                r2_d2[i]  <= r1_df[i][2];
            end

            r3_node <= r2_node;
            r3_last <= r2_last;
            r3_vhi  <= r2_pv01 * $signed(r2_pv23[PW-1:FW]);
            r3_vlo  <= r2_pv01 * $signed({1'b0, r2_pv23[FW-1:0]});
            for (int i = 0; i < 3; i++) begin
                r3_d[i] <= r2_d01[i] * r2_d2[i];
            end

            r4_node <= r3_node;
            r4_last <= r3_last;
            r4_v    <= $signed({r3_vhi, {FW{1'b0}}})
                     + $signed({{(FW - 1){r3_vlo[PW+FW]}}, r3_vlo});
            r4_d    <= r3_d;

            o_node_number <= r4_node;
            o_last_node   <= r4_last;
            o_shape_value <= hsf_pkg::round_sat({r4_v[4*FW-1], r4_v}, hsf_pkg::KV);
            o_deriv_xi    <= hsf_pkg::round_sat({{(FW + 1){r4_d[0][3*FW-1]}}, r4_d[0]},
                                                hsf_pkg::KD);
            o_deriv_eta   <= hsf_pkg::round_sat({{(FW + 1){r4_d[1][3*FW-1]}}, r4_d[1]},
                                                hsf_pkg::KD);
            o_deriv_zeta  <= hsf_pkg::round_sat({{(FW + 1){r4_d[2][3*FW-1]}}, r4_d[2]},
                                                hsf_pkg::KD);
        end
    end

endmodule

### sim/hex20_shape_function_eval_test.sv
`timescale 1ns / 1ps
// Testbench for hex20_shape_function_eval: point stimulus, node-result predictor and scoreboard.
module hex20_shape_function_eval_test;

    localparam int FRAC_BITS  = hsf_pkg::FRAC_BITS;
    localparam int IN_W       = hsf_pkg::IN_W;
    localparam int OUT_W      = hsf_pkg::OUT_W;
    localparam int NODE_W     = hsf_pkg::NODE_W;
    localparam int NODE_COUNT = hsf_pkg::NODE_COUNT;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int POINTS_PER_PHASE = 85;
    localparam int DRAIN_CYCLES = 30;

    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam logic signed [IN_W-1:0] P1 = 16'sd16384;
    localparam logic signed [IN_W-1:0] M1 = -16'sd16384;
    localparam logic signed [IN_W-1:0] CMAX = 16'sh7FFF;
    localparam logic signed [IN_W-1:0] CMIN = 16'sh8000;

    typedef struct packed {
        logic        [NODE_W-1:0] node;
        logic signed [OUT_W-1:0]  shape;
        logic signed [OUT_W-1:0]  dxi;
        logic signed [OUT_W-1:0]  deta;
        logic signed [OUT_W-1:0]  dzeta;
        logic                     last;
    } t_node_result;

    typedef struct packed {
        logic signed [IN_W-1:0]  xi;
        logic signed [IN_W-1:0]  eta;
        logic signed [IN_W-1:0]  zeta;
        logic signed [5:0]       pin_node;
        logic signed [OUT_W-1:0] pin_shape;
    } t_point_row;

    // local coordinates of the 20 nodes: corners first, then the mid-side nodes
    int node_a [NODE_COUNT] = '{-1, 1, 1,-1,-1, 1, 1,-1, 0, 1, 0,-1,-1, 1, 1,-1, 0, 1, 0,-1};
    int node_b [NODE_COUNT] = '{-1,-1, 1, 1,-1,-1, 1, 1,-1, 0, 1, 0,-1,-1, 1, 1,-1, 0, 1, 0};
    int node_c [NODE_COUNT] = '{-1,-1,-1,-1, 1, 1, 1, 1,-1,-1,-1,-1, 0, 0, 0, 0, 1, 1, 1, 1};

    t_point_row directed_points [20] = '{
        '{16'sd0,  16'sd0,  16'sd0,  -6'sd1, 17'sd0},
        '{M1,      M1,      M1,      6'sd0,  17'sd16384},
        '{P1,      P1,      P1,      6'sd6,  17'sd16384},
        '{M1,      P1,      M1,      6'sd3,  17'sd16384},
        '{P1,      M1,      P1,      6'sd5,  17'sd16384},
        '{16'sd0,  M1,      M1,      6'sd8,  17'sd16384},
        '{P1,      16'sd0,  M1,      6'sd9,  17'sd16384},
        '{M1,      M1,      16'sd0,  6'sd12, 17'sd16384},
        '{M1,      16'sd0,  P1,      6'sd19, 17'sd16384},
        '{16'sd0,  P1,      P1,      6'sd18, 17'sd16384},
        '{CMIN,    CMIN,    CMIN,    6'sd0,  hsf_pkg::OUT_MAX},
        '{CMAX,    CMAX,    CMAX,    -6'sd1, 17'sd0},
        '{CMIN,    CMAX,    CMIN,    -6'sd1, 17'sd0},
        '{CMAX,    CMIN,    16'sd0,  -6'sd1, 17'sd0},
        '{16'sd1,  -16'sd1, 16'sd1,  -6'sd1, 17'sd0},
        '{-16'sd1, 16'sd0,  16'sd0,  -6'sd1, 17'sd0},
        '{16'sd8192, -16'sd8192, 16'sd8192, -6'sd1, 17'sd0},
        '{16'sd16383, -16'sd16383, 16'sd1, -6'sd1, 17'sd0},
        '{P1,      M1,      16'sd0,  6'sd13, 17'sd16384},
        '{-16'sd12345, 16'sd9876, 16'sd30000, -6'sd1, 17'sd0}
    };

    int idle_mix  [4] = '{0, 46, 0, 35};
    int stall_mix [4] = '{0, 0, 46, 35};

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [IN_W-1:0] i_xi_coord = '0;
    logic signed [IN_W-1:0] i_eta_coord = '0;
    logic signed [IN_W-1:0] i_zeta_coord = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic        [NODE_W-1:0] o_node_number;
    logic signed [OUT_W-1:0]  o_shape_value;
    logic signed [OUT_W-1:0]  o_deriv_xi;
    logic signed [OUT_W-1:0]  o_deriv_eta;
    logic signed [OUT_W-1:0]  o_deriv_zeta;
    logic o_last_node;

    t_node_result pending_node_results [$];
    int mismatch_count = 0;
    int points_sent = 0;
    int results_seen = 0;
    int input_held_cycles = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    logic pressure_armed = 1'b0;

    hex20_shape_function_eval dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_xi_coord   (i_xi_coord),
        .i_eta_coord  (i_eta_coord),
        .i_zeta_coord (i_zeta_coord),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_node_number(o_node_number),
        .o_shape_value(o_shape_value),
        .o_deriv_xi   (o_deriv_xi),
        .o_deriv_eta  (o_deriv_eta),
        .o_deriv_zeta (o_deriv_zeta),
        .o_last_node  (o_last_node)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [127:0] product4(input longint f0, input longint f1,
                                                     input longint f2, input longint f3);
        logic signed [127:0] w0, w1, w2, w3;
        w0 = f0;
        w1 = f1;
        w2 = f2;
        w3 = f3;
        return w0 * w1 * w2 * w3;
    endfunction

    function automatic logic signed [OUT_W-1:0] round_half_up_sat(input logic signed [127:0] prod,
                                                                  input int k);
        logic signed [127:0] q;
        q = (prod + (128'sd1 <<< (k - 1))) >>> k;
        if (q > 128'sd65535) begin
            return hsf_pkg::OUT_MAX;
        end else if (q < -128'sd65536) begin
            return hsf_pkg::OUT_MIN;
        end else begin
            return q[OUT_W-1:0];
        end
    endfunction

    function automatic t_node_result eval_node(input logic signed [IN_W-1:0] xi,
                                               input logic signed [IN_W-1:0] eta,
                                               input logic signed [IN_W-1:0] zeta,
                                               input int n);
        longint x, y, z, a, b, c, px, py, pz, s;
        int kv, kd, kh;
        hsf_pkg::t_node_kind kind;
        t_node_result r;
        x = xi;
        y = eta;
        z = zeta;
        a = node_a[n];
        b = node_b[n];
        c = node_c[n];
        px = UNIT + a * x;
        py = UNIT + b * y;
        pz = UNIT + c * z;
        kv = 3 * FRAC_BITS + 2;
        kd = 2 * FRAC_BITS + 2;
        kh = 2 * FRAC_BITS + 1;
        if (a == 0) begin
            kind = hsf_pkg::KIND_MID_XI;
        end else if (b == 0) begin
            kind = hsf_pkg::KIND_MID_ETA;
        end else if (c == 0) begin
            kind = hsf_pkg::KIND_MID_ZETA;
        end else begin
            kind = hsf_pkg::KIND_CORNER;
        end
        r.node = n[NODE_W-1:0];
        r.last = (n == NODE_COUNT - 1);
        case (kind)
            hsf_pkg::KIND_CORNER: begin
                s = a * x + b * y + c * z;
                r.shape = round_half_up_sat(product4(px, py, pz, s - 2 * UNIT), kv + 1);
                r.dxi   = round_half_up_sat(product4(a, py, pz, s + a * x - UNIT), kd + 1);
                r.deta  = round_half_up_sat(product4(b, px, pz, s + b * y - UNIT), kd + 1);
                r.dzeta = round_half_up_sat(product4(c, px, py, s + c * z - UNIT), kd + 1);
            end
            hsf_pkg::KIND_MID_XI: begin
                r.shape = round_half_up_sat(product4(UNIT - x, UNIT + x, py, pz), kv);
                r.dxi   = round_half_up_sat(product4(-x, py, pz, 1), kh);
                r.deta  = round_half_up_sat(product4(UNIT - x, UNIT + x, b, pz), kd);
                r.dzeta = round_half_up_sat(product4(UNIT - x, UNIT + x, py, c), kd);
            end
            hsf_pkg::KIND_MID_ETA: begin
                r.shape = round_half_up_sat(product4(px, UNIT - y, UNIT + y, pz), kv);
                r.dxi   = round_half_up_sat(product4(a, UNIT - y, UNIT + y, pz), kd);
                r.deta  = round_half_up_sat(product4(px, -y, pz, 1), kh);
                r.dzeta = round_half_up_sat(product4(px, UNIT - y, UNIT + y, c), kd);
            end
            default: begin
                r.shape = round_half_up_sat(product4(px, py, UNIT - z, UNIT + z), kv);
                r.dxi   = round_half_up_sat(product4(a, py, UNIT - z, UNIT + z), kd);
                r.deta  = round_half_up_sat(product4(px, b, UNIT - z, UNIT + z), kd);
                r.dzeta = round_half_up_sat(product4(px, py, -z, 1), kh);
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [IN_W-1:0] random_coord();
        int pick;
        pick = $urandom_range(19);
        if (pick < 3) begin
            return (pick == 0) ? M1 : ((pick == 1) ? 16'sd0 : P1);
        end else if (pick < 6) begin
            return IN_W'($urandom);
        end else if (pick == 6) begin
            return $urandom_range(1) ? CMAX : CMIN;
        end else begin
            return IN_W'(int'($urandom_range(32768)) - 16384);
        end
    endfunction

    task automatic offer_point(input logic signed [IN_W-1:0] xi,
                               input logic signed [IN_W-1:0] eta,
                               input logic signed [IN_W-1:0] zeta,
                               input int pin_node,
                               input logic signed [OUT_W-1:0] pin_shape);
        t_node_result r;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_xi_coord <= xi;
        i_eta_coord <= eta;
        i_zeta_coord <= zeta;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        for (int n = 0; n < NODE_COUNT; n++) begin
            r = eval_node(xi, eta, zeta, n);
            if (n == pin_node) r.shape = pin_shape;
            pending_node_results.push_back(r);
        end
        points_sent++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (pressure_armed) begin
            pressure_armed <= 1'b0;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_node_result want;
        if (i_rst_n && i_valid && o_stall) input_held_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_node_results.size() == 0) begin
                $error("node %0d word with nothing pending", o_node_number);
                mismatch_count++;
            end else begin
                want = pending_node_results.pop_front();
                results_seen++;
                if (o_node_number !== want.node) begin
                    $error("node_number: expected %0d, got %0d", want.node, o_node_number);
                    mismatch_count++;
                end
                if (o_shape_value !== want.shape) begin
                    $error("shape_value: expected %0d, got %0d", want.shape, o_shape_value);
                    mismatch_count++;
                end
                if (o_deriv_xi !== want.dxi) begin
                    $error("deriv_xi: expected %0d, got %0d", want.dxi, o_deriv_xi);
                    mismatch_count++;
                end
                if (o_deriv_eta !== want.deta) begin
                    $error("deriv_eta: expected %0d, got %0d", want.deta, o_deriv_eta);
                    mismatch_count++;
                end
                if (o_deriv_zeta !== want.dzeta) begin
                    $error("deriv_zeta: expected %0d, got %0d", want.dzeta, o_deriv_zeta);
                    mismatch_count++;
                end
                if (o_last_node !== want.last) begin
                    $error("last_node: expected %0d, got %0d", want.last, o_last_node);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_points[i]) begin
            offer_point(directed_points[i].xi, directed_points[i].eta, directed_points[i].zeta,
                        directed_points[i].pin_node, directed_points[i].pin_shape);
        end

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = idle_mix[phase];
            stall_pct = stall_mix[phase];
            // hold the output long enough to back the input up
            if (phase == 0) pressure_armed <= 1'b1;
            for (int i = 0; i < POINTS_PER_PHASE; i++) begin
                offer_point(random_coord(), random_coord(), random_coord(), -1, '0);
            end
        end
        i_valid <= 1'b0;

        while (pending_node_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d points and %0d node words checked over four idle/stall mixes,",
                 points_sent, results_seen);
        $display("including a %0d-cycle output hold; input backed up for %0d cycles",
                 HOLD_CYCLES, input_held_cycles);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### hex20_shape_function_eval.f
src/hsf_pkg.sv
src/hex20_shape_function_eval.sv
sim/hex20_shape_function_eval_test.sv
